FILE: src/pctu_pkg.sv
package pctu_pkg;

  localparam int MAX_VARS = 64;
  localparam int VAR_W    = $clog2(MAX_VARS);
  localparam int NV_W     = 7;
  // One memory row per variable pair, one bit per value combination.
  localparam int ROWS     = MAX_VARS * (MAX_VARS - 1) / 2;
  localparam int ADDR_W   = $clog2(ROWS);
  localparam int TUPLE_W  = 4;
  localparam int GAIN_W   = 11;
  localparam int COUNT_W  = 13;

  localparam logic [1:0] KIND_EVAL   = 2'd0;
  localparam logic [1:0] KIND_COMMIT = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [MAX_VARS-1:0] assignment;
  } req_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [COUNT_W-1:0] covered_total;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic shift_a;
    logic load_b;
    logic shift_b;
  } cell_ctrl_t;

endpackage

FILE: src/pctu_cell.sv
module pctu_cell (
  input  logic                clk_i,
  input  pctu_pkg::cell_ctrl_t ctrl_i,
  input  logic                asg_i,
  input  logic                a_nxt_i,
  input  logic                b_nxt_i,
  output logic                a_o,
  output logic                b_o
);

  logic a_q, a_d;
  logic b_q, b_d;

  // The a chain walks the first variable of a pair, the b chain the second.
  always_comb begin
    if (ctrl_i.load) begin
      a_d = asg_i;
    end else if (ctrl_i.shift_a) begin
      a_d = a_nxt_i;
    end else begin
      a_d = a_q;
    end
    if (ctrl_i.load_b) begin
      b_d = a_nxt_i;
    end else if (ctrl_i.shift_b) begin
      b_d = b_nxt_i;
    end else begin
      b_d = b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

FILE: src/pctu_ram.sv
module pctu_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2016
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/pairwise_coverage_tracker_unit.sv
// Channel   | Ports                               | Handshake
// ----------+-------------------------------------+------------------------------
// request   | req_i (kind, assignment)            | taken when start && !busy
// result    | rsp_o (gain, covered_total)         | valid for one cycle on done_o
// config    | cfg_wdata_i (num_vars)              | written when cfg_we_i is high
//
// Evaluate and commit walk the pairs of the n variables in use, one pair per cycle
// through the read-modify-write of the coverage memory, except while the pair chain
// is reloaded at the start of each row. Clear is a sweep over all 2016 memory rows;
// an unused kind goes straight to its result.
// After reset the same sweep over all 2016 rows runs with busy high and gives no result.
// The result cannot be stalled; busy stays high until its strobe cycle has ended.
module pairwise_coverage_tracker_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  pctu_pkg::req_t              req_i,
  output logic                        done_o,
  output pctu_pkg::rsp_t              rsp_o,
  input  logic                        cfg_we_i,
  input  logic [pctu_pkg::NV_W-1:0]   cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ROW,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e                             state_q, state_d;
  logic [pctu_pkg::NV_W-1:0]          num_vars_q;
  logic [pctu_pkg::ADDR_W-1:0]        ptr_q, ptr_d;
  logic [pctu_pkg::VAR_W-1:0]         j_q, j_d;
  logic [pctu_pkg::VAR_W-1:0]         jst_q, jst_d;
  logic                               commit_q, commit_d;
  logic [pctu_pkg::GAIN_W-1:0]        gain_q, gain_d;
  logic [pctu_pkg::COUNT_W-1:0]       count_q, count_d;
  logic                               p1_valid_q, p1_valid_d;
  logic [pctu_pkg::ADDR_W-1:0]        p1_addr_q, p1_addr_d;
  logic [1:0]                         p1_sel_q, p1_sel_d;

  logic [pctu_pkg::NV_W-1:0]          eff_n;
  logic [pctu_pkg::VAR_W-1:0]         last_idx;
  logic                               sweep_end;

  pctu_pkg::cell_ctrl_t               cell_ctrl;
  logic [pctu_pkg::MAX_VARS-1:0]      a_bits, b_bits;

  logic                               ram_we;
  logic [pctu_pkg::ADDR_W-1:0]        ram_waddr;
  logic [pctu_pkg::TUPLE_W-1:0]       ram_wdata;
  logic [pctu_pkg::TUPLE_W-1:0]       ram_rdata;

  assign eff_n = (num_vars_q > pctu_pkg::NV_W'(pctu_pkg::MAX_VARS)) ?
                 pctu_pkg::NV_W'(pctu_pkg::MAX_VARS) : num_vars_q;
  assign last_idx  = pctu_pkg::VAR_W'(eff_n - pctu_pkg::NV_W'(1));
  assign sweep_end = (ptr_q == pctu_pkg::ADDR_W'(pctu_pkg::ROWS - 1));

  for (genvar k = 0; k < pctu_pkg::MAX_VARS; k++) begin : g_cell
    logic a_nxt, b_nxt;
    if (k == pctu_pkg::MAX_VARS - 1) begin : g_tail
      assign a_nxt = 1'b0;
      assign b_nxt = 1'b0;
    end else begin : g_link
      assign a_nxt = a_bits[k+1];
      assign b_nxt = b_bits[k+1];
    end
    pctu_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .asg_i   (req_i.assignment[k]),
      .a_nxt_i (a_nxt),
      .b_nxt_i (b_nxt),
      .a_o     (a_bits[k]),
      .b_o     (b_bits[k])
    );
  end

  pctu_ram #(
    .WIDTH (pctu_pkg::TUPLE_W),
    .DEPTH (pctu_pkg::ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    j_d        = j_q;
    jst_d      = jst_q;
    commit_d   = commit_q;
    gain_d     = gain_q;
    count_d    = count_q;
    p1_valid_d = 1'b0;
    p1_addr_d  = ptr_q;
    p1_sel_d   = {a_bits[0], b_bits[0]};
    cell_ctrl  = '0;
    ram_we     = 1'b0;
    ram_waddr  = p1_addr_q;
    ram_wdata  = ram_rdata | (pctu_pkg::TUPLE_W'(1) << p1_sel_q);

    // Second half of the read-modify-write: the row read last cycle is here.
    if (p1_valid_q && !ram_rdata[p1_sel_q]) begin
      gain_d = gain_q + pctu_pkg::GAIN_W'(1);
      if (commit_q) begin
        ram_we  = 1'b1;
        count_d = count_q + pctu_pkg::COUNT_W'(1);
      end
    end

    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = '0;
        ptr_d     = ptr_q + pctu_pkg::ADDR_W'(1);
        if (sweep_end) begin
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          gain_d         = '0;
          ptr_d          = '0;
          jst_d          = pctu_pkg::VAR_W'(1);
          commit_d       = (req_i.kind == pctu_pkg::KIND_COMMIT);
          cell_ctrl.load = 1'b1;
          if (req_i.kind == pctu_pkg::KIND_CLEAR) begin
            count_d = '0;
            state_d = ST_CLEAR;
          end else if (req_i.kind == pctu_pkg::KIND_EVAL ||
                       req_i.kind == pctu_pkg::KIND_COMMIT) begin
            state_d = (eff_n < pctu_pkg::NV_W'(2)) ? ST_DONE : ST_ROW;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_ROW: begin
        cell_ctrl.load_b = 1'b1;
        j_d              = jst_q;
        state_d          = ST_RUN;
      end
      ST_RUN: begin
        p1_valid_d        = 1'b1;
        cell_ctrl.shift_b = 1'b1;
        ptr_d             = ptr_q + pctu_pkg::ADDR_W'(1);
        j_d               = j_q + pctu_pkg::VAR_W'(1);
        if (j_q == last_idx) begin
          cell_ctrl.shift_a = 1'b1;
          if (jst_q == last_idx) begin
            state_d = ST_DRAIN;
          end else begin
            jst_d   = jst_q + pctu_pkg::VAR_W'(1);
            state_d = ST_ROW;
          end
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      num_vars_q <= pctu_pkg::NV_W'(pctu_pkg::MAX_VARS);
      ptr_q      <= '0;
      j_q        <= '0;
      jst_q      <= '0;
      commit_q   <= 1'b0;
      gain_q     <= '0;
      count_q    <= '0;
      p1_valid_q <= 1'b0;
      p1_addr_q  <= '0;
      p1_sel_q   <= '0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        num_vars_q <= cfg_wdata_i;
      end
      ptr_q      <= ptr_d;
      j_q        <= j_d;
      jst_q      <= jst_d;
      commit_q   <= commit_d;
      gain_q     <= gain_d;
      count_q    <= count_d;
      p1_valid_q <= p1_valid_d;
      p1_addr_q  <= p1_addr_d;
      p1_sel_q   <= p1_sel_d;
    end
  end

  assign busy                = (state_q != ST_IDLE);
  assign done_o              = (state_q == ST_DONE);
  assign rsp_o.gain          = gain_q;
  assign rsp_o.covered_total = count_q;

endmodule

FILE: src/pctu_checker.sv
module pctu_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input pctu_pkg::rsp_t rsp_o
);

  // An accepted item always makes the unit busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not make the unit busy");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("unit not idle after result");

  // The covered count moves only while an item is being worked on.
  a_count_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> $stable(rsp_o.covered_total))
    else $error("covered count changed while idle");

endmodule

bind pairwise_coverage_tracker_unit pctu_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

FILE: test/tb_pairwise_coverage_tracker_unit.sv
`timescale 1ns / 1ps

module tb_pairwise_coverage_tracker_unit;

  localparam int MAP_BITS = 4 * pctu_pkg::ROWS;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 2200;

  class pair_coverage_scoreboard;
    bit [MAP_BITS-1:0] covered_tuples;
    int unsigned covered_cnt;
    bit [pctu_pkg::NV_W-1:0] num_vars;
    pctu_pkg::rsp_t expected_rsp_q[$];
    int errors;

    function new();
      covered_tuples = '0;
      covered_cnt = 0;
      num_vars = pctu_pkg::NV_W'(pctu_pkg::MAX_VARS);
      errors = 0;
    endfunction

    function void write_num_vars(bit [pctu_pkg::NV_W-1:0] value);
      num_vars = value;
    endfunction

    function void note_request(pctu_pkg::req_t req);
      int unsigned n;
      int unsigned gain;
      int unsigned addr;
      pctu_pkg::rsp_t exp_rsp;
      n = (num_vars > pctu_pkg::MAX_VARS) ? pctu_pkg::MAX_VARS : num_vars;
      gain = 0;
      if (req.kind == pctu_pkg::KIND_CLEAR) begin
        covered_tuples = '0;
        covered_cnt = 0;
      end else if (req.kind == pctu_pkg::KIND_EVAL || req.kind == pctu_pkg::KIND_COMMIT) begin
        for (int unsigned i = 0; i + 1 < n; i++) begin
          for (int unsigned j = i + 1; j < n; j++) begin
            // Triangular pair offset, then one of four value combinations.
            addr = 4 * (((2 * n - i - 1) * i) / 2 + (j - i - 1))
                   + 2 * int'(req.assignment[i]) + int'(req.assignment[j]);
            if (addr < MAP_BITS && !covered_tuples[addr]) begin
              gain++;
              if (req.kind == pctu_pkg::KIND_COMMIT) begin
                covered_tuples[addr] = 1'b1;
                covered_cnt++;
              end
            end
          end
        end
      end
      exp_rsp.gain = gain[pctu_pkg::GAIN_W-1:0];
      exp_rsp.covered_total = covered_cnt[pctu_pkg::COUNT_W-1:0];
      expected_rsp_q = {expected_rsp_q, exp_rsp};
    endfunction

    function void check_result(pctu_pkg::rsp_t got);
      pctu_pkg::rsp_t exp_rsp;
      if (expected_rsp_q.size() == 0) begin
        $error("unexpected result: gain %0d, covered_total %0d", got.gain, got.covered_total);
        errors++;
        return;
      end
      exp_rsp = expected_rsp_q.pop_front();
      if (got.gain !== exp_rsp.gain) begin
        $error("gain: expected %0d, actual %0d", exp_rsp.gain, got.gain);
        errors++;
      end
      if (got.covered_total !== exp_rsp.covered_total) begin
        $error("covered_total: expected %0d, actual %0d", exp_rsp.covered_total,
               got.covered_total);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rsp_q.size();
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  pctu_pkg::req_t            req_i;
  logic                      done_o;
  pctu_pkg::rsp_t            rsp_o;
  logic                      cfg_we_i;
  logic [pctu_pkg::NV_W-1:0] cfg_wdata_i;

  pair_coverage_scoreboard sb = new();
  bit burst_mode;

  pairwise_coverage_tracker_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Results are checked before a new item is noted; the block never does both at one edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(rsp_o);
      if (cfg_we_i) sb.write_num_vars(cfg_wdata_i);
      if (start && !busy) sb.note_request(req_i);
    end
  end

  // Start is only lowered when a gap is drawn, so a held start never toggles within a step.
  task automatic drive_item(logic [1:0] op, logic [pctu_pkg::MAX_VARS-1:0] asg);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= pctu_pkg::req_t'{kind: op, assignment: asg};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic end_phase();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic write_num_vars_reg(logic [pctu_pkg::NV_W-1:0] value);
    while (sb.pending() != 0 || busy) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [pctu_pkg::MAX_VARS-1:0] rand_asg();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 16) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [1:0] rand_kind();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return pctu_pkg::KIND_COMMIT;
    if (pick < 82) return pctu_pkg::KIND_EVAL;
    if (pick < 93) return pctu_pkg::KIND_CLEAR;
    return KIND_UNUSED;
  endfunction

  initial begin
    int unsigned nv;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    burst_mode = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset setting of all 64 variables.
    drive_item(pctu_pkg::KIND_COMMIT, '0);
    drive_item(pctu_pkg::KIND_EVAL, '0);
    drive_item(pctu_pkg::KIND_EVAL, '1);
    drive_item(pctu_pkg::KIND_COMMIT, '1);
    drive_item(pctu_pkg::KIND_COMMIT, {32{2'b10}});
    drive_item(KIND_UNUSED, {$urandom, $urandom});
    drive_item(pctu_pkg::KIND_EVAL, {32{2'b01}});
    drive_item(pctu_pkg::KIND_CLEAR, '1);
    drive_item(pctu_pkg::KIND_COMMIT, 64'h8000_0000_0000_0001);
    end_phase();

    // Fewer than two variables leave no pairs to cover.
    write_num_vars_reg(7'd0);
    drive_item(pctu_pkg::KIND_COMMIT, '1);
    end_phase();
    write_num_vars_reg(7'd1);
    drive_item(pctu_pkg::KIND_COMMIT, {$urandom, $urandom});
    end_phase();

    // Out-of-range count saturates; the map left from before may alias new tuples.
    write_num_vars_reg(7'd127);
    drive_item(pctu_pkg::KIND_COMMIT, 64'h0123_4567_89ab_cdef);
    end_phase();

    // Three variables: every combination, with garbage in the unused high bits.
    write_num_vars_reg(7'd3);
    for (int k = 0; k < 8; k++) begin
      drive_item(pctu_pkg::KIND_COMMIT,
                 ({$urandom, $urandom} & ~64'h7) | 64'(k) | 64'hffff_0000_0000_0000);
    end
    drive_item(pctu_pkg::KIND_EVAL, '1);
    drive_item(pctu_pkg::KIND_CLEAR, '0);
    drive_item(KIND_UNUSED, '1);
    end_phase();

    write_num_vars_reg(7'd2);
    drive_item(pctu_pkg::KIND_COMMIT, 64'hffff_ffff_ffff_fffe);
    drive_item(pctu_pkg::KIND_EVAL, 64'hffff_ffff_ffff_fffe);
    end_phase();

    // Random part: mostly small sizes, a few phases at or above the maximum.
    for (int p = 0; p < 11; p++) begin
      if (p == 2 || p == 7) nv = $urandom_range(pctu_pkg::MAX_VARS, 127);
      else if (p == 9) nv = pctu_pkg::MAX_VARS;
      else if (p == 4) nv = $urandom_range(0, 1);
      else if (p == 0) nv = 2;
      else nv = $urandom_range(2, 24);
      write_num_vars_reg(nv[pctu_pkg::NV_W-1:0]);
      burst_mode = (p % 3 == 1);
      for (int k = 0; k < 24; k++) begin
        drive_item(rand_kind(), rand_asg());
      end
      end_phase();
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: pairwise_coverage_tracker_unit.f
src/pctu_pkg.sv
src/pctu_cell.sv
src/pctu_ram.sv
src/pairwise_coverage_tracker_unit.sv
src/pctu_checker.sv
test/tb_pairwise_coverage_tracker_unit.sv
